FILE: rtl/per_pkg.sv
// constants shared by the polyline even resampler
package per_pkg;

   localparam int CoordBits   = 32;
   localparam int FracBits    = 8;
   localparam int MaxPerSeg   = 64;
   localparam int CntBits     = 7;
   localparam int SpacingBits = 40;
   localparam int SegBits     = 41;
   localparam int RunBits     = 42;
   localparam int RadBits     = 82;
   localparam int RootSteps   = 41;
   localparam int QuoBits     = 32;
   localparam int RemBits     = 44;
   localparam int SubBits     = 46;
   localparam int NumBits     = 75;
   localparam int StepBits    = 6;
   localparam int CsrAddrBits = 4;
   localparam int CsrDataBits = 64;

   localparam logic [SpacingBits-1:0] SpacingReset = 40'd256;
   localparam logic                   RegSpacing   = 1'b0;

endpackage

FILE: rtl/polyline_even_resampler.sv
// Polyline even resampler: emits points spaced evenly by arc length along a polyline.
// A vertex that starts a polyline returns itself. A later vertex takes a 41-step
// square root for the segment length, then two 32-step divides for each emitted point
// (one per axis); both iterate on one shared subtractor, with one 32x32
// multiplier for the squares and products. The block accepts
// no vertex until the previous one is fully handled. A result transfer may stall freely;
// the next point waits in a holding register until the output register frees.
module polyline_even_resampler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [per_pkg::CoordBits-1:0] req_vertex_x,
   input  logic signed [per_pkg::CoordBits-1:0] req_vertex_y,
   input  logic                                req_starts_new,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [per_pkg::CoordBits-1:0] rsp_point_x,
   output logic signed [per_pkg::CoordBits-1:0] rsp_point_y,
   output logic                                rsp_last_of_run,
   output logic                                rsp_truncated,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [per_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  logic [per_pkg::CsrDataBits-1:0]     csr_pwdata,
   output logic [per_pkg::CsrDataBits-1:0]     csr_prdata,
   output logic                                csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_DIFF, ST_SQX, ST_SQY, ST_SUM, ST_ROOT,
      ST_LOOP, ST_MLO, ST_MHI, ST_NUM, ST_DIV, ST_FLUSH
   } state_type;

   localparam int CB = per_pkg::CoordBits;
   localparam int CsrIdxBit = per_pkg::CsrAddrBits - 1;

   state_type state_ff, state_in;
   logic [per_pkg::SpacingBits-1:0] spacing_ff, spacing_in;
   logic signed [CB-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [CB-1:0] vx_ff, vx_in, vy_ff, vy_in;
   logic [per_pkg::RunBits-1:0] run_ff, run_in, acc_ff, acc_in;
   logic open_ff, open_in;
   logic [CB-1:0] mx_ff, mx_in, my_ff, my_in;
   logic nx_ff, nx_in, ny_ff, ny_in;
   logic [2*CB-1:0] prod_ff, prod_in, sq_ff, sq_in, lo_ff, lo_in;
   logic [per_pkg::RadBits-1:0] rad_ff, rad_in;
   logic [per_pkg::SegBits-1:0] seg_ff, seg_in, pos_ff, pos_in;
   logic [per_pkg::RemBits-1:0] rem_ff, rem_in;
   logic [per_pkg::QuoBits-1:0] quo_ff, quo_in, dsh_ff, dsh_in;
   logic [per_pkg::StepBits-1:0] it_ff, it_in;
   logic [per_pkg::CntBits-1:0] cnt_ff, cnt_in;
   logic ax_ff, ax_in;
   logic pend_ff, pend_in;
   logic signed [CB-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_trunc_ff, rsp_trunc_in;
   logic signed [CB-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic slot_free, cfg_write;
   logic [per_pkg::SpacingBits-1:0] sp;
   logic [per_pkg::RunBits:0] total;
   logic lt, eq, cnt_full;
   logic [CB-1:0] mul_a, mul_b, mag, q_val;
   logic [2*CB-1:0] mul_p;
   logic [per_pkg::SubBits-1:0] sub_a, sub_b, sub_d;
   logic sub_ge, axis_done;
   logic [per_pkg::RunBits-1:0] gap;
   logic [per_pkg::NumBits-1:0] num_w;
   logic [2*CB:0] sum_sq;
   logic signed [CB-1:0] base_p, pt;
   logic axis_neg;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign sp = (spacing_ff == '0) ? per_pkg::SpacingBits'(1) : spacing_ff;
   assign total = (per_pkg::RunBits+1)'(acc_ff) + (per_pkg::RunBits+1)'(seg_ff)
                  - (per_pkg::RunBits+1)'(pos_ff);
   assign lt = total < (per_pkg::RunBits+1)'(sp);
   assign eq = total == (per_pkg::RunBits+1)'(sp);
   assign cnt_full = cnt_ff >= per_pkg::CntBits'(per_pkg::MaxPerSeg);
   assign gap = (per_pkg::RunBits'(sp) > acc_ff) ? per_pkg::RunBits'(sp) - acc_ff : '0;
   assign mag = ax_ff ? my_ff : mx_ff;
   assign axis_neg = ax_ff ? ny_ff : nx_ff;
   assign base_p = ax_ff ? prev_y_ff : prev_x_ff;
   assign pt = axis_neg ? base_p - $signed(q_val) : base_p + $signed(q_val);
   assign mul_p = (2*CB)'(mul_a) * (2*CB)'(mul_b);
   assign sub_d = sub_a - sub_b;
   assign sub_ge = sub_a >= sub_b;
   assign sum_sq = (2*CB+1)'(sq_ff) + (2*CB+1)'(prod_ff);
   assign num_w = (((per_pkg::NumBits'(prod_ff) << CB) + per_pkg::NumBits'(lo_ff)) << 1)
                  + per_pkg::NumBits'(seg_ff);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_point_x = rsp_x_ff;
   assign rsp_point_y = rsp_y_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_truncated = rsp_trunc_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CsrIdxBit] == per_pkg::RegSpacing) ?
                       per_pkg::CsrDataBits'(spacing_ff) : '0;

   always_comb begin
      state_in = state_ff;
      spacing_in = spacing_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      run_in = run_ff;
      acc_in = acc_ff;
      open_in = open_ff;
      mx_in = mx_ff;
      my_in = my_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      prod_in = prod_ff;
      sq_in = sq_ff;
      lo_in = lo_ff;
      rad_in = rad_ff;
      seg_in = seg_ff;
      pos_in = pos_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsh_in = dsh_ff;
      it_in = it_ff;
      cnt_in = cnt_ff;
      ax_in = ax_ff;
      pend_in = pend_ff;
      pend_x_in = pend_x_ff;
      pend_y_in = pend_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_last_in = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      mul_a = '0;
      mul_b = '0;
      sub_a = '0;
      sub_b = '0;
      axis_done = 1'b0;
      q_val = '0;

      if (cfg_write && csr_paddr[CsrIdxBit] == per_pkg::RegSpacing) begin
         spacing_in = csr_pwdata[per_pkg::SpacingBits-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               vx_in = req_vertex_x;
               vy_in = req_vertex_y;
               cnt_in = '0;
               pend_in = 1'b0;
               pos_in = '0;
               acc_in = run_ff;
               state_in = (req_starts_new || !open_ff) ? ST_START : ST_DIFF;
            end
         end
         ST_START: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = vx_ff;
               rsp_y_in = vy_ff;
               rsp_last_in = 1'b1;
               rsp_trunc_in = 1'b0;
               prev_x_in = vx_ff;
               prev_y_in = vy_ff;
               run_in = '0;
               open_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIFF: begin
            nx_in = vx_ff < prev_x_ff;
            ny_in = vy_ff < prev_y_ff;
            mx_in = (vx_ff < prev_x_ff) ? CB'(prev_x_ff - vx_ff) : CB'(vx_ff - prev_x_ff);
            my_in = (vy_ff < prev_y_ff) ? CB'(prev_y_ff - vy_ff) : CB'(vy_ff - prev_y_ff);
            state_in = ST_SQX;
         end
         ST_SQX: begin
            mul_a = mx_ff;
            mul_b = mx_ff;
            prod_in = mul_p;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            mul_a = my_ff;
            mul_b = my_ff;
            sq_in = prod_ff;
            prod_in = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in = per_pkg::RadBits'(sum_sq) << (2 * per_pkg::FracBits);
            rem_in = '0;
            seg_in = '0;
            it_in = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            sub_a = per_pkg::SubBits'({rem_ff, rad_ff[per_pkg::RadBits-1 -: 2]});
            sub_b = per_pkg::SubBits'({seg_ff, 2'b01});
            rem_in = sub_ge ? per_pkg::RemBits'(sub_d) : per_pkg::RemBits'(sub_a);
            seg_in = {seg_ff[per_pkg::SegBits-2:0], sub_ge};
            rad_in = rad_ff << 2;
            it_in = it_ff + 1'b1;
            if (it_ff == per_pkg::StepBits'(per_pkg::RootSteps - 1)) begin
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            if (!pend_ff || slot_free) begin
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in = pend_x_ff;
                  rsp_y_in = pend_y_ff;
                  rsp_last_in = lt || cnt_full;
                  rsp_trunc_in = !lt && cnt_full;
               end
               pend_in = 1'b0;
               priority if (lt || cnt_full) begin
                  run_in = lt ? per_pkg::RunBits'(total) : '0;
                  prev_x_in = vx_ff;
                  prev_y_in = vy_ff;
                  state_in = ST_IDLE;
               end else if (eq) begin
                  pend_in = 1'b1;
                  pend_x_in = vx_ff;
                  pend_y_in = vy_ff;
                  cnt_in = cnt_ff + 1'b1;
                  run_in = '0;
                  state_in = ST_FLUSH;
               end else begin
                  pos_in = pos_ff + per_pkg::SegBits'(gap);
                  acc_in = '0;
                  ax_in = 1'b0;
                  state_in = ST_MLO;
               end
            end
         end
         ST_MLO: begin
            mul_a = mag;
            mul_b = pos_ff[CB-1:0];
            prod_in = mul_p;
            state_in = ST_MHI;
         end
         ST_MHI: begin
            mul_a = mag;
            mul_b = CB'(pos_ff[per_pkg::SegBits-1:CB]);
            lo_in = prod_ff;
            prod_in = mul_p;
            state_in = ST_NUM;
         end
         ST_NUM: begin
            if (seg_ff == '0) begin
               axis_done = 1'b1;
               q_val = '0;
            end else begin
               rem_in = per_pkg::RemBits'(num_w[per_pkg::NumBits-1:CB]);
               dsh_in = num_w[CB-1:0];
               quo_in = '0;
               it_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            sub_a = per_pkg::SubBits'({rem_ff[per_pkg::RemBits-2:0], dsh_ff[CB-1]});
            sub_b = per_pkg::SubBits'({seg_ff, 1'b0});
            rem_in = sub_ge ? per_pkg::RemBits'(sub_d) : per_pkg::RemBits'(sub_a);
            quo_in = {quo_ff[per_pkg::QuoBits-2:0], sub_ge};
            dsh_in = dsh_ff << 1;
            it_in = it_ff + 1'b1;
            if (it_ff == per_pkg::StepBits'(per_pkg::QuoBits - 1)) begin
               axis_done = 1'b1;
               q_val = {quo_ff[per_pkg::QuoBits-2:0], sub_ge};
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in = pend_x_ff;
               rsp_y_in = pend_y_ff;
               rsp_last_in = 1'b1;
               rsp_trunc_in = 1'b0;
               pend_in = 1'b0;
               prev_x_in = vx_ff;
               prev_y_in = vy_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (axis_done) begin
         if (!ax_ff) begin
            pend_x_in = pt;
            ax_in = 1'b1;
            state_in = ST_MLO;
         end else begin
            pend_y_in = pt;
            pend_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            state_in = ST_LOOP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         spacing_ff <= per_pkg::SpacingReset;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         run_ff <= '0;
         open_ff <= 1'b0;
         pend_ff <= 1'b0;
         cnt_ff <= '0;
         it_ff <= '0;
         ax_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         spacing_ff <= spacing_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         run_ff <= run_in;
         open_ff <= open_in;
         pend_ff <= pend_in;
         cnt_ff <= cnt_in;
         it_ff <= it_in;
         ax_ff <= ax_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vx_ff <= vx_in;
      vy_ff <= vy_in;
      acc_ff <= acc_in;
      mx_ff <= mx_in;
      my_ff <= my_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      lo_ff <= lo_in;
      rad_ff <= rad_in;
      seg_ff <= seg_in;
      pos_ff <= pos_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsh_ff <= dsh_in;
      pend_x_ff <= pend_x_in;
      pend_y_ff <= pend_y_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   a_trunc_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> rsp_last_of_run)
      else $error("truncated flag without last_of_run");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= per_pkg::CntBits'(per_pkg::MaxPerSeg))
      else $error("point count beyond limit");

   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (it_ff < per_pkg::StepBits'(per_pkg::RootSteps)))
      else $error("square root overran its steps");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready right after a transfer");

endmodule
